// ----- rtl/dsld_pkg.sv -----
package dsld_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_DIFF   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REMOVED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ELEMENT   = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_DIFF_DONE = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;      // capture command, select and key
        logic       clear_ptr;  // zero the walk pointers
        logic       ins_step;   // one insert shift step
        logic       rem_step;   // one remove search/shift step
        logic       rd_step;    // advance readout pointer
        logic       diff_step;  // one merge step
        logic       diff_end;   // commit merged counts
    } dsld_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] command;
        logic       full;
        logic       empty;
        logic       ins_done;   // insert slot found and written
        logic       rem_done;   // walk finished
        logic       rem_found;
        logic       rd_last;
        logic       diff_done;
    } dsld_stat_t;

endpackage

// ----- rtl/dsld_datapath.sv -----
module dsld_datapath
    import dsld_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        command,
    input  logic              list_select,
    input  logic signed [31:0] key_value,
    input  dsld_cmd_t         cmd,
    output dsld_stat_t        stat,
    output logic signed [31:0] rd_elem,
    output logic [CNT_W-1:0]  cnt_a,
    output logic [CNT_W-1:0]  cnt_b
);

    logic signed [31:0] mem_a [CAPACITY];
    logic signed [31:0] mem_b [CAPACITY];

    logic [1:0]         cmd_reg;
    logic               sel_reg;
    logic signed [31:0] key_reg;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_b_reg;
    logic [CNT_W-1:0]   ia_reg, ib_reg, na_reg, nb_reg;
    logic               found_reg;

    logic [CNT_W-1:0]   n_sel;
    logic signed [31:0] ea, eb, e_prev, e_next;
    logic               more_a, more_b;

    assign n_sel = sel_reg ? cnt_b_reg : cnt_a_reg;
    assign ea    = mem_a[ia_reg[IDX_W-1:0]];
    assign eb    = mem_b[ib_reg[IDX_W-1:0]];
    assign more_a = ia_reg < cnt_a_reg;
    assign more_b = ib_reg < cnt_b_reg;

    // Insert walks down from the top; ia_reg holds the slot being filled.
    assign e_prev = sel_reg ? mem_b[IDX_W'(ia_reg - 1'b1)] : mem_a[IDX_W'(ia_reg - 1'b1)];
    // Remove walks up; ia_reg is the slot examined or being closed.
    assign e_next = sel_reg ? mem_b[IDX_W'(ia_reg + 1'b1)] : mem_a[IDX_W'(ia_reg + 1'b1)];

    logic ins_here;
    assign ins_here = (ia_reg == '0) || !(key_reg < e_prev);

    logic signed [31:0] e_cur;
    assign e_cur = sel_reg ? mem_b[ia_reg[IDX_W-1:0]] : ea;

    assign stat.command   = cmd_reg;
    assign stat.full      = n_sel == CNT_W'(CAPACITY);
    assign stat.empty     = n_sel == '0;
    assign stat.ins_done  = ins_here;
    assign stat.rem_done  = found_reg ? (ia_reg + 1'b1 >= n_sel)
                                      : (ia_reg >= n_sel || e_cur == key_reg &&
                                         ia_reg + 1'b1 >= n_sel);
    assign stat.rem_found = found_reg || (ia_reg < n_sel && e_cur == key_reg);
    assign stat.rd_last   = ia_reg + 1'b1 >= n_sel;
    assign stat.diff_done = !more_a && !more_b;

    assign rd_elem = sel_reg ? eb : ea;
    assign cnt_a   = cnt_a_reg;
    assign cnt_b   = cnt_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.latch) begin
                cmd_reg   <= command;
                sel_reg   <= list_select;
                key_reg   <= key_value;
                found_reg <= 1'b0;
                ia_reg    <= (list_select ? cnt_b_reg : cnt_a_reg);
                ib_reg    <= '0;
                na_reg    <= '0;
                nb_reg    <= '0;
            end
            if (cmd.clear_ptr) begin
                ia_reg <= '0;
                ib_reg <= '0;
            end
            if (cmd.ins_step) begin
                if (ins_here) begin
                    if (sel_reg) begin
                        mem_b[ia_reg[IDX_W-1:0]] <= key_reg;
                        cnt_b_reg <= cnt_b_reg + 1'b1;
                    end else begin
                        mem_a[ia_reg[IDX_W-1:0]] <= key_reg;
                        cnt_a_reg <= cnt_a_reg + 1'b1;
                    end
                end else begin
                    if (sel_reg) mem_b[ia_reg[IDX_W-1:0]] <= e_prev;
                    else         mem_a[ia_reg[IDX_W-1:0]] <= e_prev;
                    ia_reg <= ia_reg - 1'b1;
                end
            end
            if (cmd.rem_step) begin
                if (stat.rem_found) begin
                    found_reg <= 1'b1;
                    if (ia_reg + 1'b1 < n_sel) begin
                        if (sel_reg) mem_b[ia_reg[IDX_W-1:0]] <= e_next;
                        else         mem_a[ia_reg[IDX_W-1:0]] <= e_next;
                    end else if (sel_reg) begin
                        cnt_b_reg <= cnt_b_reg - 1'b1;
                    end else begin
                        cnt_a_reg <= cnt_a_reg - 1'b1;
                    end
                end
                ia_reg <= ia_reg + 1'b1;
            end
            if (cmd.rd_step) begin
                ia_reg <= ia_reg + 1'b1;
                ib_reg <= ib_reg + 1'b1;
            end
            // Merge in place: the write pointers never pass the read pointers.
            if (cmd.diff_step) begin
                if (more_a && (!more_b || ea < eb)) begin
                    mem_a[na_reg[IDX_W-1:0]] <= ea;
                    na_reg <= na_reg + 1'b1;
                    ia_reg <= ia_reg + 1'b1;
                end else if (more_b && (!more_a || eb < ea)) begin
                    mem_b[nb_reg[IDX_W-1:0]] <= eb;
                    nb_reg <= nb_reg + 1'b1;
                    ib_reg <= ib_reg + 1'b1;
                end else begin
                    ia_reg <= ia_reg + 1'b1;
                    ib_reg <= ib_reg + 1'b1;
                end
            end
            if (cmd.diff_end) begin
                cnt_a_reg <= na_reg;
                cnt_b_reg <= nb_reg;
            end
        end
    end

endmodule

// ----- rtl/dsld_ctrl.sv -----
module dsld_ctrl
    import dsld_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic             m_is_last,
    output logic             m_load_elem,
    output logic             m_load_cnt,
    input  dsld_stat_t       stat,
    output dsld_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_REM  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_DIFF = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_busy;
    logic       load;
    logic [2:0] st;
    logic       last;

    assign out_busy = m_valid && !m_ready;
    assign s_ready  = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd   = '0;
        load  = 1'b0;
        st    = ST_INSERTED;
        last  = 1'b1;
        m_load_elem = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.command)
                    CMD_INSERT: state_next = stat.full ? S_OUT : S_INS;
                    CMD_REMOVE: begin
                        cmd.clear_ptr = 1'b1;
                        state_next = S_REM;
                    end
                    CMD_READ: begin
                        cmd.clear_ptr = 1'b1;
                        state_next = stat.empty ? S_OUT : S_RD;
                    end
                    default: begin
                        cmd.clear_ptr = 1'b1;
                        state_next = S_DIFF;
                    end
                endcase
            end
            S_INS: begin
                cmd.ins_step = 1'b1;
                if (stat.ins_done) state_next = S_FIN;
            end
            S_REM: begin
                cmd.rem_step = 1'b1;
                if (stat.rem_done || !stat.rem_found && stat.empty) state_next = S_FIN;
            end
            S_RD: begin
                if (!out_busy) begin
                    load = 1'b1;
                    m_load_elem = 1'b1;
                    st   = ST_ELEMENT;
                    last = stat.rd_last;
                    cmd.rd_step = 1'b1;
                    if (stat.rd_last) state_next = S_IDLE;
                end
            end
            S_DIFF: begin
                if (stat.diff_done) begin
                    cmd.diff_end = 1'b1;
                    state_next = S_FIN;
                end else begin
                    cmd.diff_step = 1'b1;
                end
            end
            S_OUT: begin
                // Full insert or empty readout: counts are unchanged.
                if (!out_busy) begin
                    load = 1'b1;
                    st   = stat.command == CMD_INSERT ? ST_FULL : ST_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default: begin
                if (!out_busy) begin
                    load = 1'b1;
                    unique case (stat.command)
                        CMD_INSERT: st = ST_INSERTED;
                        CMD_REMOVE: st = stat.rem_found ? ST_REMOVED : ST_NOT_FOUND;
                        CMD_READ:   st = ST_EMPTY;
                        default:    st = ST_DIFF_DONE;
                    endcase
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign m_load_cnt = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid   <= 1'b1;
                m_status  <= st;
                m_is_last <= last;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/dual_sorted_list_difference.sv -----
// Two ascending sorted lists of signed 32-bit keys, up to 16 entries each.
// Input words (s_command, s_list_select, s_key_value) are taken on the
// s_valid/s_ready handshake; result words leave on m_valid/m_ready.
// Insert, remove and difference give one result word with m_is_last set;
// readout gives one word per entry (or a single empty word).
// One command is worked at a time; s_ready is high only while idle.
// Insert shifts entries up one at a time from the top of the list until its
// slot is found, remove walks the list from the bottom closing the gap behind
// a found key, difference merges both lists in one pass, and readout steps
// through the entries.
// A new result word is loaded only when the output register is empty or
// being drained, so a stalled receiver simply holds the readout walk in place.
// Reset (aresetn low, synchronous) empties both lists; list contents are
// not cleared, only the counts.
module dual_sorted_list_difference
    import dsld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic               s_list_select,
    input  logic signed [31:0] s_key_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_element,
    output logic               m_is_last,
    output logic [6:0]         m_count_first,
    output logic [6:0]         m_count_second
);

    dsld_cmd_t          cmd;
    dsld_stat_t         stat;
    logic signed [31:0] rd_elem;
    logic [CNT_W-1:0]   cnt_a, cnt_b;
    logic               load_elem, load_cnt;

    dsld_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .command(s_command), .list_select(s_list_select), .key_value(s_key_value),
        .cmd(cmd), .stat(stat), .rd_elem(rd_elem), .cnt_a(cnt_a), .cnt_b(cnt_b)
    );

    dsld_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_is_last(m_is_last),
        .m_load_elem(load_elem), .m_load_cnt(load_cnt),
        .stat(stat), .cmd(cmd)
    );

    always_ff @(posedge aclk) begin
        if (load_cnt) begin
            m_element      <= load_elem ? rd_elem : '0;
            m_count_first  <= 7'(cnt_a);
            m_count_second <= 7'(cnt_b);
        end
    end

endmodule

// ----- tb/dual_sorted_list_difference_tb.sv -----
module dual_sorted_list_difference_tb;
    import dsld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] element;
        logic               is_last;
        logic [6:0]         count_first;
        logic [6:0]         count_second;
    } result_word_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic               s_list_select;
    logic signed [31:0] s_key_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic signed [31:0] m_element;
    logic               m_is_last;
    logic [6:0]         m_count_first;
    logic [6:0]         m_count_second;

    dual_sorted_list_difference i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_list_select  (s_list_select),
        .s_key_value    (s_key_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_element      (m_element),
        .m_is_last      (m_is_last),
        .m_count_first  (m_count_first),
        .m_count_second (m_count_second)
    );

    // Shadow copy of both lists.
    logic signed [31:0] shadow_list [2][CAPACITY];
    int                 shadow_count [2];
    result_word_t       pending_results [$];

    int error_count;
    int word_count;
    int result_count;
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;
    int cmd_seen [4];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic result_word_t make_result(input logic [2:0] st,
                                                 input logic signed [31:0] el,
                                                 input logic last);
        result_word_t r;
        r.status       = st;
        r.element      = el;
        r.is_last      = last;
        r.count_first  = 7'(shadow_count[0]);
        r.count_second = 7'(shadow_count[1]);
        return r;
    endfunction

    task automatic list_merge_difference();
        logic signed [31:0] a [CAPACITY];
        logic signed [31:0] b [CAPACITY];
        int i, j, na, nb;
        i = 0; j = 0; na = 0; nb = 0;
        while (i < shadow_count[0] && j < shadow_count[1]) begin
            if (shadow_list[0][i] > shadow_list[1][j]) begin
                b[nb++] = shadow_list[1][j++];
            end else if (shadow_list[0][i] < shadow_list[1][j]) begin
                a[na++] = shadow_list[0][i++];
            end else begin
                i++;
                j++;
            end
        end
        while (i < shadow_count[0]) a[na++] = shadow_list[0][i++];
        while (j < shadow_count[1]) b[nb++] = shadow_list[1][j++];
        for (int k = 0; k < na; k++) shadow_list[0][k] = a[k];
        for (int k = 0; k < nb; k++) shadow_list[1][k] = b[k];
        shadow_count[0] = na;
        shadow_count[1] = nb;
    endtask

    task automatic predict_lists(input logic [1:0] cmd, input logic sel,
                                 input logic signed [31:0] key);
        int n, pos;
        logic [2:0] st;
        n = shadow_count[sel];
        cmd_seen[cmd]++;
        case (cmd)
            CMD_INSERT: begin
                if (n >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < n && key > shadow_list[sel][pos]) pos++;
                    for (int j = n; j > pos; j--) shadow_list[sel][j] = shadow_list[sel][j-1];
                    shadow_list[sel][pos] = key;
                    shadow_count[sel] = n + 1;
                    st = ST_INSERTED;
                end
                pending_results.push_back(make_result(st, 0, 1'b1));
            end
            CMD_REMOVE: begin
                st = ST_NOT_FOUND;
                for (int p = 0; p < n; p++) begin
                    if (st == ST_NOT_FOUND && shadow_list[sel][p] == key) begin
                        for (int j = p; j + 1 < n; j++) shadow_list[sel][j] = shadow_list[sel][j+1];
                        shadow_count[sel] = n - 1;
                        st = ST_REMOVED;
                    end
                end
                pending_results.push_back(make_result(st, 0, 1'b1));
            end
            CMD_READ: begin
                if (n == 0) begin
                    pending_results.push_back(make_result(ST_EMPTY, 0, 1'b1));
                end else begin
                    for (int k = 0; k < n; k++) begin
                        pending_results.push_back(
                            make_result(ST_ELEMENT, shadow_list[sel][k], k + 1 == n));
                    end
                end
            end
            default: begin
                list_merge_difference();
                pending_results.push_back(make_result(ST_DIFF_DONE, 0, 1'b1));
            end
        endcase
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic sel,
                             input logic signed [31:0] key);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_list_select <= sel;
        s_key_value   <= key;
        do @(posedge aclk); while (!s_ready);
        predict_lists(cmd, sel, key);
        word_count++;
        s_valid <= 1'b0;
        // The block is busy after taking a word; s_ready stays low while it works.
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver stall and result checking.
    always @(posedge aclk) begin
        result_word_t want;
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                result_count++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word status", m_status, -1);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_element !== want.element)
                        report_mismatch("element", m_element, want.element);
                    if (m_is_last !== want.is_last)
                        report_mismatch("is_last", m_is_last, want.is_last);
                    if (m_count_first !== want.count_first)
                        report_mismatch("count_first", m_count_first, want.count_first);
                    if (m_count_second !== want.count_second)
                        report_mismatch("count_second", m_count_second, want.count_second);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d words outstanding",
                         pending_results.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] random_key(input bit narrow);
        if (narrow) return $signed($urandom_range(12)) - 6;
        return $urandom();
    endfunction

    task automatic test_extremes();
        send_word(CMD_READ, 1'b0, 0);
        send_word(CMD_READ, 1'b1, 32'hffffffff);
        send_word(CMD_REMOVE, 1'b0, 5);
        send_word(CMD_INSERT, 1'b0, 32'sh7fffffff);
        send_word(CMD_INSERT, 1'b0, 32'sh80000000);
        send_word(CMD_INSERT, 1'b0, 0);
        send_word(CMD_INSERT, 1'b0, 0);
        send_word(CMD_INSERT, 1'b1, 0);
        send_word(CMD_INSERT, 1'b1, -1);
        send_word(CMD_INSERT, 1'b1, 32'sh7fffffff);
        send_word(CMD_READ, 1'b0, 0);
        send_word(CMD_REMOVE, 1'b0, 32'sh80000000);
        send_word(CMD_REMOVE, 1'b1, 77);
        send_word(CMD_DIFF, 1'b1, 32'h5a5a5a5a);
        send_word(CMD_READ, 1'b0, 0);
        send_word(CMD_READ, 1'b1, 0);
    endtask

    // Fill one list to capacity, then overflow it.
    task automatic test_full_list();
        for (int k = 0; k < CAPACITY + 2; k++)
            send_word(CMD_INSERT, 1'b1, random_key(1'b1));
        send_word(CMD_READ, 1'b1, 0);
        wait_drained();
    endtask

    task automatic test_random_mix(input int n_words);
        int pick;
        logic sel;
        for (int k = 0; k < n_words; k++) begin
            pick = $urandom_range(99);
            sel  = 1'($urandom_range(1));
            if (pick < 45)
                send_word(CMD_INSERT, sel, random_key($urandom_range(3) != 0));
            else if (pick < 70)
                send_word(CMD_REMOVE, sel, random_key($urandom_range(7) != 0));
            else if (pick < 88)
                send_word(CMD_READ, sel, random_key(1'b0));
            else
                send_word(CMD_DIFF, sel, random_key(1'b0));
        end
    endtask

    initial begin
        error_count   = 0;
        word_count    = 0;
        result_count  = 0;
        shadow_count  = '{0, 0};
        cmd_seen      = '{0, 0, 0, 0};
        idle_cycles   = 0;
        send_idle_pct = 11;
        recv_idle_pct = 77;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = CMD_INSERT;
        s_list_select = 1'b0;
        s_key_value   = '0;
        m_ready       = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_full_list();
        test_random_mix(25);
        send_idle_pct = 77;
        recv_idle_pct = 11;
        test_random_mix(25);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(20);
        send_word(CMD_DIFF, 1'b0, 0);
        send_word(CMD_READ, 1'b0, 0);
        send_word(CMD_READ, 1'b1, 0);

        wait_drained();
        repeat (100) @(posedge aclk);
        $display("Sent %0d words (insert %0d, remove %0d, readout %0d, difference %0d),",
                 word_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("checked %0d result words under three stall patterns.", result_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dsld_pkg.sv
rtl/dsld_datapath.sv
rtl/dsld_ctrl.sv
rtl/dual_sorted_list_difference.sv
tb/dual_sorted_list_difference_tb.sv
